/* rtl/bce_pkg.sv */
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types and constants of the betweenness centrality engine.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int VertexW   = 6;
  localparam int NumVertW  = 7;
  localparam int DistW     = 7;
  localparam int ArcW      = 2 * VertexW;
  localparam int SumW      = 32;
  localparam int NormW     = 12;
  localparam int OutFrac   = 16;
  localparam int CentW     = 16;
  localparam int ApbAddrW  = 3;
  localparam int ApbDataW  = 32;

  localparam logic [SumW-1:0]  SumLimit = 32'hFFFF_FFFF;
  localparam logic [CentW-1:0] OutLimit = 16'hFFFF;

  // register indexes on the APB port (paddr[2])
  localparam logic RegNumVertices = 1'b0;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [VertexW-1:0] arc_from;
    logic [VertexW-1:0] arc_to;
  } in_beat_t;

  typedef struct packed {
    logic [VertexW-1:0] vertex;
    logic [CentW-1:0]   centrality;
    logic               overflow;
    logic               last;
  } out_beat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR_SUM,
    ST_INIT,
    ST_SEED,
    ST_POP,
    ST_POP_W,
    ST_POP_R,
    ST_ARC_RD,
    ST_ARC_CHK,
    ST_ARC_UPD,
    ST_BK_POP,
    ST_BK_W,
    ST_BK_R,
    ST_BA_RD,
    ST_BA_CHK,
    ST_BA_F,
    ST_BA_DIV,
    ST_SUM_W,
    ST_OUT_RD,
    ST_OUT_DIV,
    ST_OUT_WAIT,
    ST_OUT_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_e;

endpackage

/* rtl/bce_ram.sv */
// ----------------------------------------------------------------------------
// bce_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bce_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/bce_muldiv.sv */
// ----------------------------------------------------------------------------
// bce_muldiv
// Shared iterative unit: q = min(floor(a * b / c), cap).
// Shift-add multiply, one multiplier bit a cycle, then restoring division,
// one quotient bit a cycle. c must be nonzero.
// ----------------------------------------------------------------------------
module bce_muldiv #(
  parameter int AW = 48,
  parameter int BW = 25,
  parameter int CW = 48,
  parameter int QW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  input  logic [CW-1:0] c_i,
  input  logic [QW-1:0] cap_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [QW-1:0] q_o
);

  localparam int PW   = AW + BW;
  localparam int CntW = $clog2(PW + 1);
  localparam int QXW  = QW + 2;

  bce_pkg::md_phase_e phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PW-1:0]   mcand_q, mcand_d;
  logic [BW-1:0]   mplr_q, mplr_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [CW-1:0]   c_q, c_d;
  logic [QW-1:0]   cap_q, cap_d;
  logic [CW-1:0]   r_q, r_d;
  logic [QW:0]     q_q, q_d;
  logic            over_q, over_d;
  logic            done_q, done_d;
  logic [QW-1:0]   res_q, res_d;

  logic [CW:0]     r_sh;
  logic            r_ge;
  logic [QXW-1:0]  q_nx;

  assign r_sh = {r_q, prod_q[PW-1]};
  assign r_ge = (r_sh >= {1'b0, c_q});
  assign q_nx = {q_q, r_ge};

  // sequencer of the unit
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    mplr_d  = mplr_q;
    prod_d  = prod_q;
    c_d     = c_q;
    cap_d   = cap_q;
    r_d     = r_q;
    q_d     = q_q;
    over_d  = over_q;
    done_d  = 1'b0;
    res_d   = res_q;
    case (phase_q)
      bce_pkg::MD_IDLE: begin
        if (start_i) begin
          mcand_d = PW'(a_i);
          mplr_d  = b_i;
          prod_d  = '0;
          c_d     = c_i;
          cap_d   = cap_i;
          r_d     = '0;
          q_d     = '0;
          over_d  = 1'b0;
          cnt_d   = CntW'(BW);
          phase_d = bce_pkg::MD_MUL;
        end
      end
      bce_pkg::MD_MUL: begin
        if (mplr_q[0]) begin
          prod_d = prod_q + mcand_q;
        end
        mcand_d = mcand_q << 1;
        mplr_d  = mplr_q >> 1;
        if (cnt_q == CntW'(1)) begin
          cnt_d   = CntW'(PW);
          phase_d = bce_pkg::MD_DIV;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      bce_pkg::MD_DIV: begin
        r_d    = r_ge ? CW'(r_sh - {1'b0, c_q}) : CW'(r_sh);
        prod_d = prod_q << 1;
        q_d    = q_nx[QW:0];
        // quotient only grows, so once past the cap it stays there
        over_d = over_q | (q_nx > QXW'(cap_q));
        if (cnt_q == CntW'(1)) begin
          done_d  = 1'b1;
          res_d   = over_d ? cap_q : q_nx[QW-1:0];
          phase_d = bce_pkg::MD_IDLE;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      default: begin
        phase_d = bce_pkg::MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bce_pkg::MD_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    mcand_q <= mcand_d;
    mplr_q  <= mplr_d;
    prod_q  <= prod_d;
    c_q     <= c_d;
    cap_q   <= cap_d;
    r_q     <= r_d;
    q_q     <= q_d;
    over_q  <= over_d;
    res_q   <= res_d;
  end

  assign busy_o = (phase_q != bce_pkg::MD_IDLE);
  assign done_o = done_q;
  assign q_o    = res_q;

endmodule

/* rtl/betweenness_centrality_engine_top.sv */
// Clear and add-arc beats: one beat per cycle while idle; input stalls during compute.
// Compute beat: clear the sums; per source, wipe the vertex records, walk forward
// over the stored arcs from each visited vertex, then walk backward, computing
// each dependency term on the shared mul/div unit; then normalize each emitted
// vertex on the same unit.
// Reset clears arc count, overflow flag, vertex count and all control state.
// ----------------------------------------------------------------------------
// betweenness_centrality_engine_top
// Brandes betweenness centrality on a stored directed graph, one sequencer
// driving one shared multiply/divide unit over RAM-held vertex state.
// ----------------------------------------------------------------------------
module betweenness_centrality_engine_top #(
  parameter int MAX_VERTICES    = 64,
  parameter int MAX_ARCS        = 1024,
  parameter int PATH_COUNT_BITS = 48,
  parameter int FRAC_BITS       = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bce_pkg::in_beat_t                 in_beat_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bce_pkg::out_beat_t                out_beat_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bce_pkg::ApbAddrW-1:0]      paddr,
  input  logic [bce_pkg::ApbDataW-1:0]      pwdata,
  output logic [bce_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready
);

  localparam int PB    = PATH_COUNT_BITS;
  localparam int DB    = FRAC_BITS + 8;
  localparam int VW    = bce_pkg::VertexW;
  localparam int NW    = bce_pkg::NumVertW;
  localparam int DW    = bce_pkg::DistW;
  localparam int VAW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int ADW   = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
  localparam int ACW   = $clog2(MAX_ARCS + 1);
  localparam int VXW   = 1 + DW + PB + DB;
  localparam int MD_AW = (PB > bce_pkg::SumW) ? PB : bce_pkg::SumW;
  localparam int MD_BW = FRAC_BITS + 9;
  localparam int MD_CW = (PB > bce_pkg::NormW + FRAC_BITS) ? PB
                                                            : bce_pkg::NormW + FRAC_BITS;
  localparam int SW    = bce_pkg::SumW;

  localparam logic [NW-1:0]  MaxV     = NW'(MAX_VERTICES);
  localparam logic [ACW-1:0] MaxArcs  = ACW'(MAX_ARCS);
  localparam logic [PB-1:0]  PathMax  = {PB{1'b1}};
  localparam logic [DB-1:0]  DepMax   = {DB{1'b1}};

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  bce_pkg::state_e state_q, state_d;
  logic [NW-1:0]   num_vertices_q;
  logic [ACW-1:0]  arc_cnt_q, arc_cnt_d;
  logic            ovf_q, ovf_d;
  logic [NW-1:0]   s_q, s_d;
  logic [NW-1:0]   v_q, v_d;
  logic [NW-1:0]   head_q, head_d;
  logic [NW-1:0]   tail_q, tail_d;
  logic [NW-1:0]   k_q, k_d;
  logic [ACW-1:0]  a_q, a_d;
  logic [VW-1:0]   u_q, u_d;
  logic [DW-1:0]   u_dist_q, u_dist_d;
  logic [PB-1:0]   u_path_q, u_path_d;
  logic [DB-1:0]   u_dep_q, u_dep_d;
  logic [VW-1:0]   f_q, f_d;
  logic [DW-1:0]   f_dist_q, f_dist_d;
  logic [PB-1:0]   f_path_q, f_path_d;
  logic [DB-1:0]   f_dep_q, f_dep_d;
  logic [bce_pkg::NormW-1:0] norm_q, norm_d;
  logic [bce_pkg::CentW-1:0] cent_q, cent_d;
  logic            out_valid_q, out_valid_d;
  bce_pkg::out_beat_t out_beat_q, out_beat_d;

  // --------------------------------------------------------------------------
  // memory ports
  // --------------------------------------------------------------------------
  logic             arc_we;
  logic [ADW-1:0]   arc_waddr, arc_raddr;
  logic [bce_pkg::ArcW-1:0] arc_wdata, arc_rdata;
  logic             vtx_we;
  logic [VAW-1:0]   vtx_waddr, vtx_raddr;
  logic [VXW-1:0]   vtx_wdata, vtx_rdata;
  logic             vis_we;
  logic [VAW-1:0]   vis_waddr, vis_raddr;
  logic [VW-1:0]    vis_wdata, vis_rdata;
  logic             sum_we;
  logic [VAW-1:0]   sum_waddr, sum_raddr;
  logic [SW-1:0]    sum_wdata, sum_rdata;

  // shared unit
  logic              md_start, md_busy, md_done;
  logic [MD_AW-1:0]  md_a;
  logic [MD_BW-1:0]  md_b;
  logic [MD_CW-1:0]  md_c;
  logic [DB-1:0]     md_cap, md_q;

  // --------------------------------------------------------------------------
  // decode helpers
  // --------------------------------------------------------------------------
  logic [NW-1:0]   n_eff;
  logic            in_acc, out_acc, cfg_wr;
  logic [VW-1:0]   arc_f, arc_t;
  logic            vx_reached;
  logic [DW-1:0]   vx_dist;
  logic [PB-1:0]   vx_path;
  logic [DB-1:0]   vx_dep;
  logic [NW-1:0]   k_m1;

  assign n_eff      = (num_vertices_q > MaxV) ? MaxV : num_vertices_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign arc_f      = arc_rdata[bce_pkg::ArcW-1:VW];
  assign arc_t      = arc_rdata[VW-1:0];
  assign vx_reached = vtx_rdata[VXW-1];
  assign vx_dist    = vtx_rdata[VXW-2 -: DW];
  assign vx_path    = vtx_rdata[DB +: PB];
  assign vx_dep     = vtx_rdata[DB-1:0];
  assign k_m1       = k_q - NW'(1);

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bce_pkg::RegNumVertices) ?
                  bce_pkg::ApbDataW'(num_vertices_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vertices_q <= '0;
    end else if (cfg_wr && paddr[2] == bce_pkg::RegNumVertices) begin
      num_vertices_q <= pwdata[NW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // sequencer: next state, memory controls and unit operands
  // --------------------------------------------------------------------------
  always_comb begin
    logic          nr;
    logic [DW-1:0] nd;
    logic [PB-1:0] np;
    logic [PB:0]   psum;
    logic [DB:0]   dsum;
    logic [SW:0]   ssum;

    state_d     = state_q;
    arc_cnt_d   = arc_cnt_q;
    ovf_d       = ovf_q;
    s_d         = s_q;
    v_d         = v_q;
    head_d      = head_q;
    tail_d      = tail_q;
    k_d         = k_q;
    a_d         = a_q;
    u_d         = u_q;
    u_dist_d    = u_dist_q;
    u_path_d    = u_path_q;
    u_dep_d     = u_dep_q;
    f_d         = f_q;
    f_dist_d    = f_dist_q;
    f_path_d    = f_path_q;
    f_dep_d     = f_dep_q;
    norm_d      = norm_q;
    cent_d      = cent_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_beat_d  = out_beat_q;

    arc_we    = 1'b0;
    arc_waddr = arc_cnt_q[ADW-1:0];
    arc_wdata = {in_beat_i.arc_from, in_beat_i.arc_to};
    arc_raddr = a_q[ADW-1:0];
    vtx_we    = 1'b0;
    vtx_waddr = v_q[VAW-1:0];
    vtx_wdata = '0;
    vtx_raddr = u_q[VAW-1:0];
    vis_we    = 1'b0;
    vis_waddr = tail_q[VAW-1:0];
    vis_wdata = f_q;
    vis_raddr = head_q[VAW-1:0];
    sum_we    = 1'b0;
    sum_waddr = v_q[VAW-1:0];
    sum_wdata = '0;
    sum_raddr = v_q[VAW-1:0];

    md_start = 1'b0;
    md_a     = MD_AW'(f_path_q);
    md_b     = MD_BW'(u_dep_q) + (MD_BW'(1) << FRAC_BITS);
    md_c     = MD_CW'(u_path_q);
    md_cap   = DepMax;

    nr   = 1'b0;
    nd   = '0;
    np   = '0;
    psum = '0;
    dsum = '0;
    ssum = '0;

    case (state_q)
      bce_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_beat_i.op)
            bce_pkg::OP_CLEAR: begin
              arc_cnt_d = '0;
              ovf_d     = 1'b0;
            end
            bce_pkg::OP_ADD: begin
              if ({1'b0, in_beat_i.arc_from} < n_eff &&
                  {1'b0, in_beat_i.arc_to} < n_eff) begin
                if (arc_cnt_q >= MaxArcs) begin
                  ovf_d = 1'b1;
                end else begin
                  arc_we    = 1'b1;
                  arc_cnt_d = arc_cnt_q + ACW'(1);
                end
              end
            end
            bce_pkg::OP_RUN: begin
              if (n_eff != '0) begin
                v_d     = '0;
                state_d = bce_pkg::ST_CLR_SUM;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // clear the running sums
      bce_pkg::ST_CLR_SUM: begin
        sum_we = 1'b1;
        if (v_q + NW'(1) == n_eff) begin
          v_d     = '0;
          s_d     = '0;
          state_d = bce_pkg::ST_INIT;
        end else begin
          v_d = v_q + NW'(1);
        end
      end

      // per source: wipe vertex records
      bce_pkg::ST_INIT: begin
        vtx_we = 1'b1;
        if (v_q + NW'(1) == n_eff) begin
          state_d = bce_pkg::ST_SEED;
        end else begin
          v_d = v_q + NW'(1);
        end
      end

      bce_pkg::ST_SEED: begin
        vtx_we    = 1'b1;
        vtx_waddr = s_q[VAW-1:0];
        vtx_wdata = {1'b1, DW'(0), PB'(1), DB'(0)};
        vis_we    = 1'b1;
        vis_waddr = '0;
        vis_wdata = s_q[VW-1:0];
        head_d    = '0;
        tail_d    = NW'(1);
        state_d   = bce_pkg::ST_POP;
      end

      // forward walk: pop next vertex from the visit queue
      bce_pkg::ST_POP: begin
        if (head_q < tail_q) begin
          state_d = bce_pkg::ST_POP_W;
        end else begin
          k_d     = tail_q;
          state_d = bce_pkg::ST_BK_POP;
        end
      end

      bce_pkg::ST_POP_W: begin
        u_d       = vis_rdata;
        vtx_raddr = vis_rdata[VAW-1:0];
        state_d   = bce_pkg::ST_POP_R;
      end

      bce_pkg::ST_POP_R: begin
        u_dist_d = vx_dist;
        u_path_d = vx_path;
        a_d      = '0;
        state_d  = bce_pkg::ST_ARC_RD;
      end

      bce_pkg::ST_ARC_RD: begin
        if (a_q < arc_cnt_q) begin
          state_d = bce_pkg::ST_ARC_CHK;
        end else begin
          head_d  = head_q + NW'(1);
          state_d = bce_pkg::ST_POP;
        end
      end

      bce_pkg::ST_ARC_CHK: begin
        if (arc_f != u_q || {1'b0, arc_t} >= n_eff) begin
          a_d     = a_q + ACW'(1);
          state_d = bce_pkg::ST_ARC_RD;
        end else begin
          vtx_raddr = arc_t[VAW-1:0];
          f_d       = arc_t;
          state_d   = bce_pkg::ST_ARC_UPD;
        end
      end

      // discover target and add path counts along a shortest-path arc
      bce_pkg::ST_ARC_UPD: begin
        nr = vx_reached;
        nd = vx_dist;
        np = vx_path;
        if (!vx_reached && tail_q < MaxV) begin
          nr     = 1'b1;
          nd     = u_dist_q + DW'(1);
          vis_we = 1'b1;
          tail_d = tail_q + NW'(1);
        end
        if (nr && nd == u_dist_q + DW'(1)) begin
          psum = {1'b0, vx_path} + {1'b0, u_path_q};
          if (psum[PB]) begin
            np    = PathMax;
            ovf_d = 1'b1;
          end else begin
            np = psum[PB-1:0];
          end
        end
        vtx_we    = 1'b1;
        vtx_waddr = f_q[VAW-1:0];
        vtx_wdata = {nr, nd, np, vx_dep};
        a_d       = a_q + ACW'(1);
        state_d   = bce_pkg::ST_ARC_RD;
      end

      // backward walk in reverse visit order
      bce_pkg::ST_BK_POP: begin
        vis_raddr = k_m1[VAW-1:0];
        if (k_q == '0) begin
          if (s_q + NW'(1) == n_eff) begin
            v_d     = '0;
            norm_d  = bce_pkg::NormW'(n_eff - NW'(1)) * bce_pkg::NormW'(n_eff - NW'(2));
            state_d = bce_pkg::ST_OUT_RD;
          end else begin
            s_d     = s_q + NW'(1);
            v_d     = '0;
            state_d = bce_pkg::ST_INIT;
          end
        end else begin
          state_d = bce_pkg::ST_BK_W;
        end
      end

      bce_pkg::ST_BK_W: begin
        u_d       = vis_rdata;
        vtx_raddr = vis_rdata[VAW-1:0];
        state_d   = bce_pkg::ST_BK_R;
      end

      bce_pkg::ST_BK_R: begin
        u_dist_d = vx_dist;
        u_path_d = vx_path;
        u_dep_d  = vx_dep;
        a_d      = '0;
        state_d  = bce_pkg::ST_BA_RD;
      end

      bce_pkg::ST_BA_RD: begin
        sum_raddr = u_q[VAW-1:0];
        if (a_q < arc_cnt_q && u_path_q != '0) begin
          state_d = bce_pkg::ST_BA_CHK;
        end else if ({1'b0, u_q} != s_q) begin
          state_d = bce_pkg::ST_SUM_W;
        end else begin
          k_d     = k_m1;
          state_d = bce_pkg::ST_BK_POP;
        end
      end

      bce_pkg::ST_BA_CHK: begin
        if (arc_t != u_q || {1'b0, arc_f} >= n_eff) begin
          a_d     = a_q + ACW'(1);
          state_d = bce_pkg::ST_BA_RD;
        end else begin
          vtx_raddr = arc_f[VAW-1:0];
          f_d       = arc_f;
          state_d   = bce_pkg::ST_BA_F;
        end
      end

      // predecessor on a shortest path: start its dependency term
      bce_pkg::ST_BA_F: begin
        if (!vx_reached || vx_dist + DW'(1) != u_dist_q) begin
          a_d     = a_q + ACW'(1);
          state_d = bce_pkg::ST_BA_RD;
        end else begin
          f_dist_d = vx_dist;
          f_path_d = vx_path;
          f_dep_d  = vx_dep;
          md_start = 1'b1;
          md_a     = MD_AW'(vx_path);
          state_d  = bce_pkg::ST_BA_DIV;
        end
      end

      bce_pkg::ST_BA_DIV: begin
        if (md_done) begin
          dsum      = {1'b0, f_dep_q} + {1'b0, md_q};
          vtx_we    = 1'b1;
          vtx_waddr = f_q[VAW-1:0];
          vtx_wdata = {1'b1, f_dist_q, f_path_q, dsum[DB] ? DepMax : dsum[DB-1:0]};
          a_d       = a_q + ACW'(1);
          state_d   = bce_pkg::ST_BA_RD;
        end
      end

      // accumulate dependency into the running sum
      bce_pkg::ST_SUM_W: begin
        ssum      = {1'b0, sum_rdata} + (SW + 1)'(u_dep_q);
        sum_we    = 1'b1;
        sum_waddr = u_q[VAW-1:0];
        sum_wdata = ssum[SW] ? bce_pkg::SumLimit : ssum[SW-1:0];
        k_d       = k_m1;
        state_d   = bce_pkg::ST_BK_POP;
      end

      // normalize and emit one vertex
      bce_pkg::ST_OUT_RD: begin
        state_d = bce_pkg::ST_OUT_DIV;
      end

      bce_pkg::ST_OUT_DIV: begin
        if (n_eff >= NW'(3)) begin
          md_start = 1'b1;
          md_a     = MD_AW'(sum_rdata);
          md_b     = MD_BW'(1) << bce_pkg::OutFrac;
          md_c     = MD_CW'(norm_q) << FRAC_BITS;
          md_cap   = DB'(bce_pkg::OutLimit);
          state_d  = bce_pkg::ST_OUT_WAIT;
        end else begin
          cent_d  = '0;
          state_d = bce_pkg::ST_OUT_EMIT;
        end
      end

      bce_pkg::ST_OUT_WAIT: begin
        if (md_done) begin
          cent_d  = md_q[bce_pkg::CentW-1:0];
          state_d = bce_pkg::ST_OUT_EMIT;
        end
      end

      bce_pkg::ST_OUT_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_beat_d.vertex     = v_q[VW-1:0];
          out_beat_d.centrality = cent_q;
          out_beat_d.overflow   = ovf_q;
          out_beat_d.last       = (v_q + NW'(1) == n_eff);
          if (v_q + NW'(1) == n_eff) begin
            state_d = bce_pkg::ST_IDLE;
          end else begin
            v_d     = v_q + NW'(1);
            state_d = bce_pkg::ST_OUT_RD;
          end
        end
      end

      default: begin
        state_d = bce_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bce_pkg::ST_IDLE;
      arc_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      arc_cnt_q   <= arc_cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    s_q        <= s_d;
    v_q        <= v_d;
    head_q     <= head_d;
    tail_q     <= tail_d;
    k_q        <= k_d;
    a_q        <= a_d;
    u_q        <= u_d;
    u_dist_q   <= u_dist_d;
    u_path_q   <= u_path_d;
    u_dep_q    <= u_dep_d;
    f_q        <= f_d;
    f_dist_q   <= f_dist_d;
    f_path_q   <= f_path_d;
    f_dep_q    <= f_dep_d;
    norm_q     <= norm_d;
    cent_q     <= cent_d;
    out_beat_q <= out_beat_d;
  end

  assign in_stall_o  = (state_q != bce_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // --------------------------------------------------------------------------
  // storage
  // --------------------------------------------------------------------------
  bce_ram #(.Width(bce_pkg::ArcW), .Depth(MAX_ARCS)) u_arc_ram (
    .clk_i   (clk_i),
    .we_i    (arc_we),
    .waddr_i (arc_waddr),
    .wdata_i (arc_wdata),
    .raddr_i (arc_raddr),
    .rdata_o (arc_rdata)
  );

  bce_ram #(.Width(VXW), .Depth(MAX_VERTICES)) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vtx_we),
    .waddr_i (vtx_waddr),
    .wdata_i (vtx_wdata),
    .raddr_i (vtx_raddr),
    .rdata_o (vtx_rdata)
  );

  bce_ram #(.Width(VW), .Depth(MAX_VERTICES)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  bce_ram #(.Width(SW), .Depth(MAX_VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  bce_muldiv #(.AW(MD_AW), .BW(MD_BW), .CW(MD_CW), .QW(DB)) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .c_i     (md_c),
    .cap_i   (md_cap),
    .busy_o  (md_busy),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_md_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_start |-> !md_busy)
    else $error("mul/div started while busy");

  a_arcs_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bce_pkg::ST_IDLE) |=> $stable(arc_cnt_q))
    else $error("arc count changed during compute");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bce_pkg::ST_POP) |-> (tail_q <= n_eff))
    else $error("visit queue longer than vertex count");

  a_arc_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arc_cnt_q <= MaxArcs)
    else $error("arc count beyond capacity");

endmodule

/* tb/betweenness_centrality_engine_top_tb.sv */
// ----------------------------------------------------------------------------
// betweenness_centrality_engine_top_tb
// Self-checking bench for the betweenness centrality engine. Arc, clear and
// compute beats go in with random gaps while the output side stalls on its
// own pattern. A scoreboard recomputes Brandes centrality for every compute
// beat, and each result beat is compared field by field in order.
// ----------------------------------------------------------------------------
module betweenness_centrality_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxVert   = 64;
  localparam int MaxArcs   = 1024;
  localparam int PathBits  = 48;
  localparam int FracBits  = 16;
  localparam int IdleLimit = 3000000;
  localparam int Settle    = 400;
  localparam int NumItems  = 330;

  // Golden centrality calculator and result checker
  class centrality_scoreboard;
    bit [bce_pkg::ArcW-1:0] arc_mem [MaxArcs];
    int unsigned   arc_cnt;
    bit            ovf;
    int unsigned   vert_reg;
    bce_pkg::out_beat_t expected_beats [$];
    int            mismatches;

    function new();
      arc_cnt = 0;
      ovf = 0;
      vert_reg = 0;
      mismatches = 0;
    endfunction

    function void set_vertices(int unsigned v);
      vert_reg = v & 127;
    endfunction

    // Work out every result beat that one accepted input beat causes
    function void note_input(bce_pkg::in_beat_t b);
      int unsigned n, head, tail, u, f, t, v, s;
      int          k;
      int unsigned hop [MaxVert];
      bit          seen [MaxVert];
      bit [63:0]   sigma [MaxVert];
      bit [63:0]   delta [MaxVert];
      int unsigned order [MaxVert];
      bit [31:0]   csum [MaxVert];
      bit [63:0]   pmax, dmax, acc, wgt, cval, norm;
      bit [127:0]  prod;
      bce_pkg::out_beat_t r;
      n = (vert_reg > MaxVert) ? MaxVert : vert_reg;
      pmax = (64'd1 << PathBits) - 1;
      dmax = (64'd1 << (FracBits + 8)) - 1;
      case (b.op)
        bce_pkg::OP_CLEAR: begin
          arc_cnt = 0;
          ovf = 0;
        end
        bce_pkg::OP_ADD: begin
          if (b.arc_from < n && b.arc_to < n) begin
            if (arc_cnt >= MaxArcs) ovf = 1;
            else begin
              arc_mem[arc_cnt] = {b.arc_from, b.arc_to};
              arc_cnt++;
            end
          end
        end
        bce_pkg::OP_RUN: begin
          for (v = 0; v < MaxVert; v++) csum[v] = 0;
          for (s = 0; s < n; s++) begin
            for (v = 0; v < n; v++) begin
              seen[v] = 0; hop[v] = 0; sigma[v] = 0; delta[v] = 0;
            end
            seen[s] = 1;
            sigma[s] = 1;
            order[0] = s;
            head = 0;
            tail = 1;
            // forward walk: distances and shortest path counts
            while (head < tail) begin
              u = order[head];
              head++;
              for (int a = 0; a < arc_cnt; a++) begin
                f = arc_mem[a][bce_pkg::ArcW-1:bce_pkg::VertexW];
                t = arc_mem[a][bce_pkg::VertexW-1:0];
                if (f != u || t >= n) continue;
                if (!seen[t]) begin
                  seen[t] = 1;
                  hop[t] = hop[u] + 1;
                  order[tail] = t;
                  tail++;
                end
                if (hop[t] == hop[u] + 1) begin
                  acc = sigma[t] + sigma[u];
                  if (acc > pmax) begin
                    acc = pmax;
                    ovf = 1;
                  end
                  sigma[t] = acc;
                end
              end
            end
            // backward walk: dependency accumulation in Q8.16
            for (k = tail - 1; k >= 0; k--) begin
              u = order[k];
              wgt = (64'd1 << FracBits) + delta[u];
              if (sigma[u] != 0) begin
                for (int a = 0; a < arc_cnt; a++) begin
                  f = arc_mem[a][bce_pkg::ArcW-1:bce_pkg::VertexW];
                  t = arc_mem[a][bce_pkg::VertexW-1:0];
                  if (t != u || f >= n || !seen[f] || hop[f] + 1 != hop[u]) continue;
                  prod = sigma[f] * wgt;
                  prod = prod / sigma[u];
                  acc = (prod > dmax) ? dmax : prod[63:0];
                  acc = delta[f] + acc;
                  delta[f] = (acc > dmax) ? dmax : acc;
                end
              end
              if (u != s) begin
                acc = csum[u] + delta[u];
                csum[u] = (acc > 64'hFFFF_FFFF) ? bce_pkg::SumLimit : acc[31:0];
              end
            end
          end
          // normalized output, one beat per vertex
          for (v = 0; v < n; v++) begin
            cval = 0;
            if (n >= 3) begin
              norm = (n - 1) * (n - 2);
              cval = ({32'd0, csum[v]} << bce_pkg::OutFrac) / (norm << FracBits);
              if (cval > bce_pkg::OutLimit) cval = bce_pkg::OutLimit;
            end
            r.vertex = bce_pkg::VertexW'(v);
            r.centrality = cval[bce_pkg::CentW-1:0];
            r.overflow = ovf;
            r.last = (v + 1 == n);
            expected_beats.insert(expected_beats.size(), r);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_result(bce_pkg::out_beat_t got);
      bce_pkg::out_beat_t want;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: vertex %0d centrality %0d", got.vertex,
                   got.centrality);
        return;
      end
      want = expected_beats.pop_front();
      if (got.vertex !== want.vertex || got.centrality !== want.centrality ||
          got.overflow !== want.overflow || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected v%0d c%0d ovf%0d last%0d, got v%0d c%0d ovf%0d last%0d",
                   want.vertex, want.centrality, want.overflow, want.last,
                   got.vertex, got.centrality, got.overflow, got.last);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  bce_pkg::in_beat_t   in_beat_i;
  logic                out_valid_o;
  logic                out_stall_i;
  bce_pkg::out_beat_t  out_beat_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [bce_pkg::ApbAddrW-1:0] paddr;
  logic [bce_pkg::ApbDataW-1:0] pwdata;
  logic [bce_pkg::ApbDataW-1:0] prdata;
  logic                pready;

  centrality_scoreboard sb;
  int                   beats_sent;
  int                   burst_left;
  int                   hold_req;
  int                   idle_cycles;

  betweenness_centrality_engine_top dut (.*);

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Output-side stall pattern; the long hold-off starts once results appear
  always @(posedge clk_i) begin
    int unsigned cyc;
    int          mode;
    int          hold_left;
    bit          hold_used;
    cyc++;
    if (cyc % 64 == 0) mode = $urandom_range(0, 2);
    if (hold_req > 0 && !hold_used && out_valid_o) begin
      hold_left = hold_req;
      hold_used = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Result monitor and idle watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_beat_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offer one beat, with bursty gaps, and hold it until accepted
  task automatic send_beat(bit [1:0] op, int unsigned from, int unsigned to);
    bce_pkg::in_beat_t b;
    int       gap;
    b.op = op;
    b.arc_from = bce_pkg::VertexW'(from);
    b.arc_to = bce_pkg::VertexW'(to);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b);
    beats_sent++;
  endtask

  // Drain the output side and let the engine settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // Register write while idle: setup then access cycle
  task automatic write_vertices(int unsigned v);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {bce_pkg::RegNumVertices, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_vertices(v);
  endtask

  initial begin
    int n, nvert, narcs, hold_done;
    sb = new();
    beats_sent = 0;
    burst_left = 0;
    hold_req = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_beat_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: small graph with duplicates, self loop, rejects, undefined op
    write_vertices(3);
    send_beat(bce_pkg::OP_CLEAR, 0, 0);
    send_beat(bce_pkg::OP_ADD, 0, 1);
    send_beat(bce_pkg::OP_ADD, 1, 2);
    send_beat(bce_pkg::OP_ADD, 0, 1);
    send_beat(bce_pkg::OP_ADD, 2, 2);
    send_beat(bce_pkg::OP_ADD, 3, 0);
    send_beat(bce_pkg::OP_ADD, 0, 63);
    send_beat(2'd3, 63, 63);
    send_beat(bce_pkg::OP_RUN, 0, 0);
    // Empty graph and fewer than three vertices
    write_vertices(0);
    send_beat(bce_pkg::OP_RUN, 0, 0);
    write_vertices(2);
    send_beat(bce_pkg::OP_ADD, 0, 1);
    send_beat(bce_pkg::OP_ADD, 1, 0);
    send_beat(bce_pkg::OP_RUN, 0, 0);
    // Largest vertex count, then an over-range register value
    write_vertices(64);
    send_beat(bce_pkg::OP_CLEAR, 0, 0);
    send_beat(bce_pkg::OP_ADD, 63, 0);
    send_beat(bce_pkg::OP_ADD, 0, 63);
    send_beat(bce_pkg::OP_ADD, 0, 42);
    send_beat(bce_pkg::OP_ADD, 42, 21);
    send_beat(bce_pkg::OP_RUN, 63, 63);
    write_vertices(100);
    send_beat(bce_pkg::OP_ADD, 21, 63);
    send_beat(bce_pkg::OP_RUN, 0, 0);

    // Shrink the vertex count so stored arcs are skipped
    write_vertices(3);
    send_beat(bce_pkg::OP_CLEAR, 0, 0);
    for (int i = 0; i < 30; i++)
      send_beat(bce_pkg::OP_ADD, $urandom_range(0, 2), $urandom_range(0, 2));
    write_vertices(2);
    send_beat(bce_pkg::OP_RUN, 0, 0);
    write_vertices(1);
    send_beat(bce_pkg::OP_RUN, 0, 0);

    // Path count saturation: 25-vertex chain, four parallel arcs per link
    write_vertices(25);
    send_beat(bce_pkg::OP_CLEAR, 0, 0);
    for (int i = 0; i < 24; i++)
      repeat (4) send_beat(bce_pkg::OP_ADD, i, i + 1);
    send_beat(bce_pkg::OP_RUN, 0, 0);
    send_beat(bce_pkg::OP_CLEAR, 0, 0);
    send_beat(bce_pkg::OP_RUN, 0, 0);

    // Random graphs, one compute per phase, two in the long hold-off phase
    hold_done = 0;
    while (beats_sent < NumItems) begin
      n = $urandom_range(0, 9);
      if (n < 7) nvert = $urandom_range(3, 8);
      else if (n == 7) nvert = $urandom_range(0, 2);
      else if (n == 8) nvert = $urandom_range(9, 20);
      else nvert = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 127);
      write_vertices(nvert);
      narcs = (nvert <= 8) ? $urandom_range(0, 14) : (nvert <= 20) ?
              $urandom_range(0, 10) : $urandom_range(0, 8);
      if ($urandom_range(0, 4) != 0) send_beat(bce_pkg::OP_CLEAR, $urandom, $urandom);
      for (int i = 0; i < narcs; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat($urandom_range(0, 1) ? 2'd3 : bce_pkg::OP_ADD, $urandom, $urandom);
        else if (nvert > 0)
          send_beat(bce_pkg::OP_ADD, $urandom_range(0, (nvert > 64 ? 64 : nvert) - 1),
                    $urandom_range(0, (nvert > 64 ? 64 : nvert) - 1));
      end
      // long output hold-off while more beats queue up behind the compute
      if (!hold_done && nvert >= 3) begin
        hold_req = 500;
        hold_done = 1;
        send_beat(bce_pkg::OP_RUN, $urandom, $urandom);
        send_beat(bce_pkg::OP_ADD, 0, 1);
        send_beat(bce_pkg::OP_ADD, 1, 2);
        send_beat(bce_pkg::OP_ADD, 2, 0);
      end
      send_beat(bce_pkg::OP_RUN, $urandom, $urandom);
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bce_pkg.sv
rtl/bce_ram.sv
rtl/bce_muldiv.sv
rtl/betweenness_centrality_engine_top.sv
tb/betweenness_centrality_engine_top_tb.sv
